[rtl/core/dmhq_pkg.sv]
// Shared constants, types and helper functions for the d-ary min-heap queue.
// No dependencies; every other file of the block but dmhq_ram imports this package.
package dmhq_pkg;

  localparam int CAPACITY    = 32;
  localparam int ARITY       = 2;
  localparam int KEY_W       = 32;
  localparam int COUNT_OUT_W = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = $clog2(CAPACITY * ARITY + 2);
  localparam int KID_W   = $clog2(ARITY + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Keys are held with the sign bit flipped so that unsigned compares order them.
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } dmhq_op_t;

  typedef struct packed {
    dmhq_op_t         op;
    logic [KEY_W-1:0] key;
  } dmhq_cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_UP_RD,
    ENG_UP_CMP,
    ENG_EX_ROOT,
    ENG_EX_LAST,
    ENG_DN_START,
    ENG_DN_SCAN,
    ENG_DN_MOVE
  } dmhq_eng_state_t;

  // Parent slot of a heap position, resolved as a small constant table.
  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] par;
    par = '0;
    for (int p = 0; p < CAPACITY; p++) begin
      if ((int'(pos) >= p * ARITY + 1) && (int'(pos) <= p * ARITY + ARITY)) begin
        par = IDX_W'(p);
      end
    end
    return par;
  endfunction

endpackage

[rtl/core/dmhq_in_if.sv]
// Input channel of the heap queue: valid/ready handshake with opcode and key.
// Depends on dmhq_pkg for the key width.
interface dmhq_in_if;
  import dmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

[rtl/core/dmhq_out_if.sv]
// Result channel of the heap queue: valid/ready handshake with the result fields.
// Depends on dmhq_pkg for the field widths.
interface dmhq_out_if;
  import dmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] min_value;
  logic                    min_valid;
  logic                    insert_dropped;
  logic [COUNT_OUT_W-1:0]  stored_count;

  modport source (output valid, output min_value, output min_valid,
                  output insert_dropped, output stored_count, input ready);
  modport sink (input valid, input min_value, input min_valid,
                input insert_dropped, input stored_count, output ready);
endinterface

[rtl/core/dary_min_heap_queue_top.sv]
// Min-priority queue on a d-ary heap held in one registered-read RAM.
// A dropped insert or an empty extract finishes as it is accepted, and an extract that takes the
// last key once the root is read. An insert compares with one parent after another until a
// parent is no larger or the root is reached; other extracts read the root and the last key and
// sift it down, reading each level's children one at a time through the single RAM read port.
// Throughput is one item per engine run; the front and queue keep accepting meanwhile until full.
// Reset (synchronous, active low) empties the queue and clears all handshakes.
module dary_min_heap_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  dmhq_in_if.sink    in_ch,
  dmhq_out_if.source out_ch
);
  import dmhq_pkg::*;

  logic      front_valid;
  logic      front_ready;
  dmhq_cmd_t front_cmd;
  logic      eng_valid;
  logic      eng_ready;
  dmhq_cmd_t eng_cmd;

  dmhq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (front_valid),
    .cmd_data  (front_cmd),
    .cmd_ready (front_ready)
  );

  dmhq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (eng_valid),
    .pop_ready  (eng_ready),
    .pop_data   (eng_cmd)
  );

  dmhq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (eng_valid),
    .cmd_ready (eng_ready),
    .cmd_data  (eng_cmd),
    .out_ch    (out_ch)
  );

endmodule

[rtl/core/dmhq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

[rtl/core/dmhq_front.sv]
// Front end: accepts input items, biases the key and forms a command.
// Depends on dmhq_pkg and dmhq_in_if.
module dmhq_front (
  input  logic               clk,
  input  logic               rst_n,
  dmhq_in_if.sink            in_ch,
  output logic               cmd_valid,
  output dmhq_pkg::dmhq_cmd_t cmd_data,
  input  logic               cmd_ready
);
  import dmhq_pkg::*;

  logic      hold_valid_r;
  dmhq_cmd_t hold_r;
  logic      in_take;

  assign in_ch.ready = !hold_valid_r || cmd_ready;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cmd_valid   = hold_valid_r;
  assign cmd_data    = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_take) begin
      hold_valid_r <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r.op  <= in_ch.opcode ? OP_EXTRACT : OP_INSERT;
      hold_r.key <= in_ch.value ^ SIGN_FLIP;
    end
  end

endmodule

[rtl/core/dmhq_cmd_fifo.sv]
// Short command queue between the front end and the heap engine.
// Depends on dmhq_pkg.
module dmhq_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  dmhq_pkg::dmhq_cmd_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dmhq_pkg::dmhq_cmd_t pop_data
);
  import dmhq_pkg::*;

  dmhq_cmd_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              push;
  logic              pop;

  assign push_ready = fill_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + QCNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/dmhq_engine.sv]
// Back end: carries out inserts and extracts on the heap memory and holds the result.
// Depends on dmhq_pkg, dmhq_out_if and dmhq_ram.
module dmhq_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dmhq_pkg::dmhq_cmd_t cmd_data,
  dmhq_out_if.source          out_ch
);
  import dmhq_pkg::*;

  dmhq_eng_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]   par_r, par_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [KEY_W-1:0]   bestval_r, bestval_nxt;
  logic [CHILD_W-1:0] kid_r, kid_nxt;
  logic [KID_W-1:0]   nkid_r, nkid_nxt;
  logic [KEY_W-1:0]   res_min_r, res_min_nxt;
  logic               res_vld_r, res_vld_nxt;
  logic               res_drop_r, res_drop_nxt;

  logic                   out_valid_r;
  logic [KEY_W-1:0]       out_min_r;
  logic                   out_vld_r;
  logic                   out_drop_r;
  logic [COUNT_OUT_W-1:0] out_cnt_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             finish;

  logic               start;
  logic               is_insert;
  logic               full;
  logic               empty;
  logic               pos_zero;
  logic               up_stop;
  logic               dn_stop;
  logic               last_one;
  logic [CHILD_W-1:0] first_w;
  logic [CHILD_W-1:0] count_ext;
  logic [CHILD_W-1:0] next_kid;
  logic               no_child;
  logic               more;
  logic               take;
  logic [KEY_W-1:0]   scan_val;
  logic [IDX_W-1:0]   scan_idx;

  dmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_ready = (state_r == ENG_IDLE) && (!out_valid_r || out_ch.ready);
  assign start     = cmd_valid && cmd_ready;
  assign is_insert = cmd_data.op == OP_INSERT;
  assign full      = count_r == CNT_W'(CAPACITY);
  assign empty     = count_r == '0;
  assign last_one  = count_r == CNT_W'(1);
  assign pos_zero  = pos_r == '0;
  assign up_stop   = rd_data <= key_r;
  assign dn_stop   = bestval_r >= key_r;
  assign first_w   = CHILD_W'(pos_r) * CHILD_W'(ARITY) + CHILD_W'(1);
  assign count_ext = CHILD_W'(count_r);
  assign no_child  = first_w >= count_ext;
  assign next_kid  = kid_r + CHILD_W'(1);
  assign more      = (nkid_r < KID_W'(ARITY)) && (next_kid < count_ext);
  assign take      = (nkid_r == KID_W'(1)) || (rd_data < bestval_r);
  assign scan_val  = take ? rd_data : bestval_r;
  assign scan_idx  = take ? kid_r[IDX_W-1:0] : best_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ENG_IDLE: begin
        if (start) begin
          if (is_insert) begin
            state_nxt = full ? ENG_IDLE : ENG_UP_RD;
          end else begin
            state_nxt = empty ? ENG_IDLE : ENG_EX_ROOT;
          end
        end
      end
      ENG_UP_RD:    state_nxt = pos_zero ? ENG_IDLE : ENG_UP_CMP;
      ENG_UP_CMP:   state_nxt = up_stop ? ENG_IDLE : ENG_UP_RD;
      ENG_EX_ROOT:  state_nxt = last_one ? ENG_IDLE : ENG_EX_LAST;
      ENG_EX_LAST:  state_nxt = ENG_DN_START;
      ENG_DN_START: state_nxt = no_child ? ENG_IDLE : ENG_DN_SCAN;
      ENG_DN_SCAN:  state_nxt = more ? ENG_DN_SCAN : ENG_DN_MOVE;
      ENG_DN_MOVE:  state_nxt = dn_stop ? ENG_IDLE : ENG_DN_START;
      default:      state_nxt = ENG_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    par_nxt      = par_r;
    best_nxt     = best_r;
    key_nxt      = key_r;
    bestval_nxt  = bestval_r;
    kid_nxt      = kid_r;
    nkid_nxt     = nkid_r;
    res_min_nxt  = res_min_r;
    res_vld_nxt  = res_vld_r;
    res_drop_nxt = res_drop_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = key_r;
    rd_addr      = '0;
    finish       = 1'b0;
    case (state_r)
      ENG_IDLE: begin
        if (start) begin
          res_min_nxt  = '0;
          res_vld_nxt  = !is_insert && !empty;
          res_drop_nxt = is_insert && full;
          key_nxt      = cmd_data.key;
          if (is_insert) begin
            if (full) begin
              finish = 1'b1;
            end else begin
              pos_nxt   = IDX_W'(count_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (empty) begin
            finish = 1'b1;
          end
        end
      end
      ENG_UP_RD: begin
        if (pos_zero) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_addr = parent_of(pos_r);
          par_nxt = parent_of(pos_r);
        end
      end
      ENG_UP_CMP: begin
        wr_en = 1'b1;
        if (up_stop) begin
          finish = 1'b1;
        end else begin
          wr_data = rd_data;
          pos_nxt = par_r;
        end
      end
      ENG_EX_ROOT: begin
        res_min_nxt = rd_data ^ SIGN_FLIP;
        count_nxt   = count_r - CNT_W'(1);
        rd_addr     = IDX_W'(count_r - CNT_W'(1));
        if (last_one) begin
          finish = 1'b1;
        end
      end
      ENG_EX_LAST: begin
        key_nxt = rd_data;
        pos_nxt = '0;
      end
      ENG_DN_START: begin
        if (no_child) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_addr  = first_w[IDX_W-1:0];
          kid_nxt  = first_w;
          nkid_nxt = KID_W'(1);
        end
      end
      ENG_DN_SCAN: begin
        bestval_nxt = scan_val;
        best_nxt    = scan_idx;
        if (more) begin
          rd_addr  = next_kid[IDX_W-1:0];
          kid_nxt  = next_kid;
          nkid_nxt = nkid_r + KID_W'(1);
        end
      end
      ENG_DN_MOVE: begin
        wr_en = 1'b1;
        if (dn_stop) begin
          finish = 1'b1;
        end else begin
          wr_data = bestval_r;
          pos_nxt = best_r;
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    par_r      <= par_nxt;
    best_r     <= best_nxt;
    key_r      <= key_nxt;
    bestval_r  <= bestval_nxt;
    kid_r      <= kid_nxt;
    nkid_r     <= nkid_nxt;
    res_min_r  <= res_min_nxt;
    res_vld_r  <= res_vld_nxt;
    res_drop_r <= res_drop_nxt;
    if (finish) begin
      out_min_r  <= res_min_nxt;
      out_vld_r  <= res_vld_nxt;
      out_drop_r <= res_drop_nxt;
      out_cnt_r  <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.min_value      = out_min_r;
  assign out_ch.min_valid      = out_vld_r;
  assign out_ch.insert_dropped = out_drop_r;
  assign out_ch.stored_count   = out_cnt_r;

endmodule
